>>> design/ufbs_pkg.sv
// Shared types and constants for the union-find (union by size) block.
// Used by ufbs_ctrl, ufbs_dp, the top level and the checker.
// Depends on nothing.
`timescale 1ns / 1ps

package ufbs_pkg;

    // Field widths of the request and the result.
    localparam int ELEM_W   = 11;
    localparam int SIZE_W   = 11;
    localparam int TDATA_IW = 24;
    localparam int TDATA_OW = 24;

    // Element count after reset.
    localparam logic [ELEM_W-1:0] COUNT_RESET = 11'd1024;

    // Operation codes carried in tuser.
    localparam logic OP_FIND  = 1'b0;
    localparam logic OP_UNION = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // latch the request and its range check
        logic clr_wr;      // clearing pass write at the sweep index
        logic use_b;       // the walk starts at elem_b instead of elem_a
        logic rd_start;    // read parent of the start element
        logic up_step;     // one hop toward the root
        logic cmp_step;    // one hop of path compression
        logic save_ra;     // first root found
        logic save_rb;     // second root found
        logic sz_rd_ra;    // read size of the first root
        logic sz_rd_rb;    // read size of the second root, keep the first
        logic link;        // link smaller root under larger, add sizes
        logic sz_rd_res;   // read size of the result root
        logic cap_size;    // capture the result size
        logic finish_bad;  // build an out-of-range result
        logic load_out;    // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;    // sweep index is at the last entry
        logic at_root;     // parent read equals the current node
        logic cmp_done;    // compression walk has reached the root
        logic bad;         // the latched request is out of range
        logic is_union;    // the latched request is a union
        logic same_root;   // both roots are the same element
        logic out_free;    // output register can take a result
    } t_sts;

endpackage

>>> design/ufbs_ctrl.sv
// Controller state machine for the union-find block.
// Sequences the clearing pass, root walks, compression and linking.
// Depends on ufbs_pkg.
`timescale 1ns / 1ps

module ufbs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ufbs_pkg::t_sts i_sts,
    output ufbs_pkg::t_cmd o_cmd
);
    import ufbs_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_F_ISSUE,
        ST_F_WALK,
        ST_C_ISSUE,
        ST_C_WALK,
        ST_SZ_RES,
        ST_SZ_CAP,
        ST_SZ_A,
        ST_SZ_B,
        ST_LINK,
        ST_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_second, n_second;

    // Next state and the second-walk flag.
    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_second = 1'b0;
                n_state  = i_sts.bad ? ST_DONE : ST_F_ISSUE;
            end
            ST_F_ISSUE: n_state = ST_F_WALK;
            ST_F_WALK: begin
                if (i_sts.at_root) n_state = ST_C_ISSUE;
            end
            ST_C_ISSUE: n_state = ST_C_WALK;
            ST_C_WALK: begin
                if (i_sts.cmp_done) begin
                    if (!r_second) begin
                        if (i_sts.is_union) begin
                            n_second = 1'b1;
                            n_state  = ST_F_ISSUE;
                        end else begin
                            n_state = ST_SZ_RES;
                        end
                    end else begin
                        n_state = i_sts.same_root ? ST_SZ_RES : ST_SZ_A;
                    end
                end
            end
            ST_SZ_RES: n_state = ST_SZ_CAP;
            ST_SZ_CAP: n_state = ST_DONE;
            ST_SZ_A:   n_state = ST_SZ_B;
            ST_SZ_B:   n_state = ST_LINK;
            ST_LINK:   n_state = ST_DONE;
            ST_DONE: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default:   n_state = ST_CLEAR;
        endcase
    end

    // State and flag registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
        end
    end

    // Commands decoded from the current state.
    always_comb begin
        o_cmd       = '0;
        o_cmd.use_b = r_second;
        unique case (r_state)
            ST_CLEAR:   o_cmd.clr_wr     = 1'b1;
            ST_IDLE:    o_cmd.accept     = i_in_valid;
            ST_CHECK:   o_cmd.finish_bad = i_sts.bad;
            ST_F_ISSUE: o_cmd.rd_start   = 1'b1;
            ST_F_WALK:  o_cmd.up_step    = 1'b1;
            ST_C_ISSUE: o_cmd.rd_start   = 1'b1;
            ST_C_WALK: begin
                o_cmd.cmp_step = 1'b1;
                o_cmd.save_ra  = i_sts.cmp_done && !r_second;
                o_cmd.save_rb  = i_sts.cmp_done && r_second;
            end
            ST_SZ_RES:  o_cmd.sz_rd_res  = 1'b1;
            ST_SZ_CAP:  o_cmd.cap_size   = 1'b1;
            ST_SZ_A:    o_cmd.sz_rd_ra   = 1'b1;
            ST_SZ_B:    o_cmd.sz_rd_rb   = 1'b1;
            ST_LINK:    o_cmd.link       = 1'b1;
            ST_DONE:    o_cmd.load_out   = i_sts.out_free;
            default:    o_cmd            = '0;
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

>>> design/ufbs_dp.sv
// Datapath for the union-find block: parent and size memories, walk
// registers, range check, element count register and output register.
// Depends on ufbs_pkg.
`timescale 1ns / 1ps

module ufbs_dp #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ufbs_pkg::t_cmd              i_cmd,
    output ufbs_pkg::t_sts              o_sts,
    input  logic                        i_cfg_we,
    input  logic [ufbs_pkg::ELEM_W-1:0] i_cfg_wdata,
    input  logic                        i_op,
    input  logic [ufbs_pkg::ELEM_W-1:0] i_elem_a,
    input  logic [ufbs_pkg::ELEM_W-1:0] i_elem_b,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [ufbs_pkg::ELEM_W-1:0] o_root,
    output logic [ufbs_pkg::SIZE_W-1:0] o_set_size,
    output logic                        o_merged,
    output logic                        o_range_error
);
    import ufbs_pkg::*;

    localparam int          IW    = $clog2(MAX_ELEMENTS + 1);
    localparam logic [31:0] MAX_U = 32'(MAX_ELEMENTS);

    // Memories, indexed by element number; entry zero is never used.
    logic [IW-1:0]     r_parent_mem [0:MAX_ELEMENTS];
    logic [SIZE_W-1:0] r_size_mem   [0:MAX_ELEMENTS];

    logic [IW-1:0]     r_p_rdata;
    logic [SIZE_W-1:0] r_s_rdata;

    logic [IW-1:0]     r_clr;
    logic [ELEM_W-1:0] r_count;
    logic              r_op;
    logic              r_bad;
    logic [ELEM_W-1:0] r_a;
    logic [ELEM_W-1:0] r_b;
    logic [IW-1:0]     r_node;
    logic [IW-1:0]     r_root;
    logic [IW-1:0]     r_ra;
    logic [IW-1:0]     r_rb;
    logic [SIZE_W-1:0] r_sa;
    logic [IW-1:0]     r_res_root;
    logic [SIZE_W-1:0] r_res_size;
    logic              r_res_merged;
    logic              r_res_err;
    logic              r_out_valid;
    logic [ELEM_W-1:0] r_out_root;
    logic [SIZE_W-1:0] r_out_size;
    logic              r_out_merged;
    logic              r_out_err;

    logic              bad_a;
    logic              bad_b;
    logic [IW-1:0]     start_idx;
    logic              at_root;
    logic              cmp_done;
    logic              a_small;
    logic [IW-1:0]     big;
    logic [IW-1:0]     small_root;
    logic [SIZE_W:0]   sum_full;
    logic [SIZE_W-1:0] sum;

    logic              p_we;
    logic              p_re;
    logic [IW-1:0]     p_waddr;
    logic [IW-1:0]     p_wdata;
    logic [IW-1:0]     p_raddr;
    logic              s_we;
    logic              s_re;
    logic [IW-1:0]     s_waddr;
    logic [SIZE_W-1:0] s_wdata;
    logic [IW-1:0]     s_raddr;

    // Range check of the incoming element numbers.
    assign bad_a = (i_elem_a == '0) || (i_elem_a > r_count) || (32'(i_elem_a) > MAX_U);
    assign bad_b = (i_elem_b == '0) || (i_elem_b > r_count) || (32'(i_elem_b) > MAX_U);

    // Walk conditions and the link decision.
    assign start_idx  = i_cmd.use_b ? IW'(r_b) : IW'(r_a);
    assign at_root    = (r_p_rdata == r_node);
    assign cmp_done   = (r_node == r_root);
    assign a_small    = !(r_sa > r_s_rdata);
    assign big        = a_small ? r_rb : r_ra;
    assign small_root = a_small ? r_ra : r_rb;
    assign sum_full   = {1'b0, r_sa} + {1'b0, r_s_rdata};
    assign sum        = sum_full[SIZE_W-1:0];

    // Parent memory port control.
    always_comb begin
        p_re    = i_cmd.rd_start || (i_cmd.up_step && !at_root)
                  || (i_cmd.cmp_step && !cmp_done);
        p_raddr = i_cmd.rd_start ? start_idx : r_p_rdata;
        p_we    = 1'b0;
        p_waddr = r_node;
        p_wdata = r_root;
        priority if (i_cmd.clr_wr) begin
            p_we    = 1'b1;
            p_waddr = r_clr;
            p_wdata = r_clr;
        end else if (i_cmd.link) begin
            p_we    = 1'b1;
            p_waddr = small_root;
            p_wdata = big;
        end else if (i_cmd.cmp_step && !cmp_done) begin
            p_we = 1'b1;
        end
    end

    // Size memory port control.
    always_comb begin
        s_re    = i_cmd.sz_rd_ra || i_cmd.sz_rd_rb || i_cmd.sz_rd_res;
        s_raddr = r_res_root;
        priority if (i_cmd.sz_rd_ra) begin
            s_raddr = r_ra;
        end else if (i_cmd.sz_rd_rb) begin
            s_raddr = r_rb;
        end
        s_we    = i_cmd.clr_wr || i_cmd.link;
        s_waddr = i_cmd.clr_wr ? r_clr : big;
        s_wdata = i_cmd.clr_wr ? SIZE_W'(1) : sum;
    end

    // Parent memory with registered read.
    always_ff @(posedge i_clk) begin
        if (p_we) r_parent_mem[p_waddr] <= p_wdata;
        if (p_re) r_p_rdata <= r_parent_mem[p_raddr];
    end

    // Size memory with registered read.
    always_ff @(posedge i_clk) begin
        if (s_we) r_size_mem[s_waddr] <= s_wdata;
        if (s_re) r_s_rdata <= r_size_mem[s_raddr];
    end

    // Control registers: sweep index, element count, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_count     <= COUNT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) r_clr <= r_clr + 1'b1;
            if (i_cfg_we) r_count <= i_cfg_wdata;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request, walk and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_op;
            r_a   <= i_elem_a;
            r_b   <= i_elem_b;
            r_bad <= bad_a || ((i_op == OP_UNION) && bad_b);
        end
        if (i_cmd.rd_start) r_node <= start_idx;
        if (i_cmd.up_step) begin
            if (at_root) r_root <= r_node;
            else         r_node <= r_p_rdata;
        end
        if (i_cmd.cmp_step && !cmp_done) r_node <= r_p_rdata;
        if (i_cmd.save_ra) begin
            r_ra         <= r_root;
            r_res_root   <= r_root;
            r_res_merged <= 1'b0;
            r_res_err    <= 1'b0;
        end
        if (i_cmd.save_rb) r_rb <= r_root;
        if (i_cmd.sz_rd_rb) r_sa <= r_s_rdata;
        if (i_cmd.link) begin
            r_res_root   <= big;
            r_res_size   <= sum;
            r_res_merged <= 1'b1;
        end
        if (i_cmd.cap_size) r_res_size <= r_s_rdata;
        if (i_cmd.finish_bad) begin
            r_res_root   <= '0;
            r_res_size   <= '0;
            r_res_merged <= 1'b0;
            r_res_err    <= 1'b1;
        end
        if (i_cmd.load_out) begin
            r_out_root   <= ELEM_W'(r_res_root);
            r_out_size   <= r_res_size;
            r_out_merged <= r_res_merged;
            r_out_err    <= r_res_err;
        end
    end

    // Status back to the controller.
    always_comb begin
        o_sts.clr_last  = (r_clr == IW'(MAX_ELEMENTS));
        o_sts.at_root   = at_root;
        o_sts.cmp_done  = cmp_done;
        o_sts.bad       = r_bad;
        o_sts.is_union  = (r_op == OP_UNION);
        o_sts.same_root = (r_ra == r_root);
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_root        = r_out_root;
    assign o_set_size    = r_out_size;
    assign o_merged      = r_out_merged;
    assign o_range_error = r_out_err;

endmodule

>>> design/union_find_by_size_top.sv
// Top level of the union-find store with union by size and path compression.
// Joins ufbs_ctrl and ufbs_dp; depends on ufbs_pkg.
//
// Usage: each request on the s_axis channel is a find (tuser 0) or a union
// (tuser 1) of elements numbered from one. Each request gives one result on
// m_axis: the root of the first element's set after the request, that set's
// size, whether a union joined two sets, and a range error flag. Requests are
// handled one at a time. A find does an upward walk to the root and then a
// compression walk; each hop of the upward walk and of the compression walk
// is one read of the parent memory. A union does two walks plus two size
// reads and the link write, or two walks and a size read of the result root
// when both elements already share a root. A request with an element out of
// range skips the walks. The element count must be written through i_cfg_we
// only while the block is idle; the user is bound to this, as the block
// does not enforce it. After reset the block sweeps both memories, entries
// 0 to MAX_ELEMENTS, one entry a cycle, with s_axis_tready low. A result
// waits in the output register while m_axis_tready is low; the next request
// is still accepted and worked on, and waits for that register to drain.
`timescale 1ns / 1ps

module union_find_by_size_top #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ufbs_pkg::ELEM_W-1:0]   i_cfg_wdata,    // element_count
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ufbs_pkg::TDATA_IW-1:0] s_axis_tdata,   // elem_a, elem_b, zero pad
    input  logic [0:0]                    s_axis_tuser,   // op
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ufbs_pkg::TDATA_OW-1:0] m_axis_tdata    // root, set_size, merged,
                                                          // range_error
);
    import ufbs_pkg::*;

    t_cmd              cmd;
    t_sts              sts;
    logic [ELEM_W-1:0] root;
    logic [SIZE_W-1:0] set_size;
    logic              merged;
    logic              range_error;

    // Sequencer.
    ufbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Memories and registers.
    ufbs_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_op          (s_axis_tuser[0]),
        .i_elem_a      (s_axis_tdata[ELEM_W-1:0]),
        .i_elem_b      (s_axis_tdata[2*ELEM_W-1:ELEM_W]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_root        (root),
        .o_set_size    (set_size),
        .o_merged      (merged),
        .o_range_error (range_error)
    );

    // Result packing: root in the lowest bits, range_error in the top bit.
    assign m_axis_tdata = {range_error, merged, set_size, root};

endmodule

>>> design/ufbs_checker.sv
// Port-level checks for the union-find top level, attached by bind.
// Depends on ufbs_pkg and on union_find_by_size_top.
`timescale 1ns / 1ps

module ufbs_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [ufbs_pkg::TDATA_OW-1:0] m_axis_tdata
);
    import ufbs_pkg::*;

    // Reset leaves nothing on the output and starts the clearing sweep.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !s_axis_tready)
        else $error("outputs active right after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // One request at a time: ready drops after an accept.
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while busy");

    // An out-of-range result carries no root, size or merge.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[TDATA_OW-1] |-> m_axis_tdata[TDATA_OW-2:0] == '0)
        else $error("range error with nonzero fields");

    // A good result names a real root and a nonempty set.
    a_good_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[TDATA_OW-1]
        |-> m_axis_tdata[ELEM_W-1:0] != '0 && m_axis_tdata[ELEM_W+SIZE_W-1:ELEM_W] != '0)
        else $error("good result with zero root or size");

endmodule

bind union_find_by_size_top ufbs_checker u_ufbs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> tb/ufbs_shadow_pkg.sv
// Scoreboard for the union-find block: a shadow copy of the disjoint-set
// store that predicts each result and checks the block's output against it.
// Depends on ufbs_pkg.
`timescale 1ns / 1ps

package ufbs_shadow_pkg;

    import ufbs_pkg::*;

    localparam int N_ELEM = 1024;

    // One result, laid out as the block packs it on m_axis_tdata.
    typedef struct packed {
        logic              range_error;
        logic              merged;
        logic [SIZE_W-1:0] set_size;
        logic [ELEM_W-1:0] root;
    } t_outcome;

    class disjoint_set_shadow;

        logic [ELEM_W-1:0] parent_of [0:N_ELEM];
        logic [SIZE_W-1:0] size_of   [0:N_ELEM];
        logic [ELEM_W-1:0] count;
        t_outcome          awaited [$];
        int                mismatches;
        int                results;
        int                finds;
        int                unions;
        int                joins;
        int                rejects;

        function new();
            for (int i = 0; i <= N_ELEM; i++) begin
                parent_of[i] = ELEM_W'(i);
                size_of[i]   = SIZE_W'(1);
            end
            count      = COUNT_RESET;
            mismatches = 0;
            results    = 0;
            finds      = 0;
            unions     = 0;
            joins      = 0;
            rejects    = 0;
        endfunction

        function void set_count(logic [ELEM_W-1:0] value);
            count = value;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Walk up to the root, then point every node on the way straight at it.
        function logic [ELEM_W-1:0] find_root(logic [ELEM_W-1:0] start);
            logic [ELEM_W-1:0] node;
            logic [ELEM_W-1:0] top;
            logic [ELEM_W-1:0] next;
            node = start;
            while (parent_of[node] != node)
                node = parent_of[node];
            top  = node;
            node = start;
            while (node != top) begin
                next            = parent_of[node];
                parent_of[node] = top;
                node            = next;
            end
            return top;
        endfunction

        // Apply an accepted request to the shadow store and queue its result.
        function void note_request(logic op, logic [ELEM_W-1:0] a, logic [ELEM_W-1:0] b);
            t_outcome          res;
            int                limit;
            logic [ELEM_W-1:0] ra;
            logic [ELEM_W-1:0] rb;
            logic [ELEM_W-1:0] lesser;
            logic [ELEM_W-1:0] greater;
            limit = (int'(count) < N_ELEM) ? int'(count) : N_ELEM;
            res   = '0;
            if (a < 1 || int'(a) > limit ||
                (op == OP_UNION && (b < 1 || int'(b) > limit))) begin
                // An element out of range leaves the store untouched.
                res.range_error = 1'b1;
                rejects++;
            end else begin
                ra       = find_root(a);
                res.root = ra;
                if (op == OP_UNION) begin
                    unions++;
                    rb = find_root(b);
                    if (ra != rb) begin
                        // The smaller set goes under the larger; on a tie a's root moves.
                        lesser  = ra;
                        greater = rb;
                        if (size_of[ra] > size_of[rb]) begin
                            lesser  = rb;
                            greater = ra;
                        end
                        parent_of[lesser] = greater;
                        size_of[greater]  = size_of[greater] + size_of[lesser];
                        res.merged        = 1'b1;
                        res.root          = greater;
                        joins++;
                    end
                end else begin
                    finds++;
                end
                res.set_size = size_of[res.root];
            end
            awaited.push_back(res);
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void check_result(logic [TDATA_OW-1:0] word);
            t_outcome got;
            t_outcome want;
            got = word;
            results++;
            if (awaited.size() == 0) begin
                $error("result 0x%06h arrived with no request outstanding", word);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            if (got.root !== want.root) begin
                $error("root: expected %0d, got %0d", want.root, got.root);
                mismatches++;
            end
            if (got.set_size !== want.set_size) begin
                $error("set_size: expected %0d, got %0d", want.set_size, got.set_size);
                mismatches++;
            end
            if (got.merged !== want.merged) begin
                $error("merged: expected %0b, got %0b", want.merged, got.merged);
                mismatches++;
            end
            if (got.range_error !== want.range_error) begin
                $error("range_error: expected %0b, got %0b", want.range_error, got.range_error);
                mismatches++;
            end
        endfunction

    endclass

endpackage

>>> tb/tb_union_find_by_size_top.sv
// Testbench for union_find_by_size_top: directed and random find and union
// requests over several element counts, checked by the shadow store.
// Depends on ufbs_pkg, ufbs_shadow_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_union_find_by_size_top;

    import ufbs_pkg::*;
    import ufbs_shadow_pkg::*;

    localparam int IDLE_PCT = 19;
    localparam int PHASES   = 9;
    localparam int QUIET    = 2;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_we      = 1'b0;
    logic [ELEM_W-1:0]   i_cfg_wdata   = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [TDATA_IW-1:0] s_axis_tdata  = '0;  // elem_a, elem_b, zero pad
    logic [0:0]          s_axis_tuser  = '0;  // op
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_OW-1:0] m_axis_tdata;  // root, set_size, merged, range_error

    disjoint_set_shadow shadow;
    bit                 gaps_on = 1'b1;
    int unsigned        window_lo;
    int unsigned        window_w;

    int unsigned phase_count [PHASES] = '{16, 1, 1024, 2, 200, 1024, 64, 1000, 1024};
    int unsigned phase_items [PHASES] = '{170, 60, 200, 60, 170, 200, 170, 190, 200};

    union_find_by_size_top #(
        .MAX_ELEMENTS(N_ELEM)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Result side: back-pressure at random, none during the quiet phase.
    always @(posedge i_clk) begin
        m_axis_tready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
    end

    // Every result that the block hands over is checked against the shadow.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            shadow.check_result(m_axis_tdata);
    end

    // Present one request, possibly after a few idle cycles, and wait for it to be taken.
    task automatic send_request(input logic op, input logic [ELEM_W-1:0] a,
                                input logic [ELEM_W-1:0] b);
        if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, b, a};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        shadow.note_request(op, a, b);
    endtask

    function automatic logic [ELEM_W-1:0] pick_element(int unsigned span);
        if ($urandom_range(1))
            return ELEM_W'(window_lo + $urandom_range(window_w - 1));
        return ELEM_W'($urandom_range(span, 1));
    endfunction

    // Mostly valid requests, half their elements drawn from a window so that sets grow and merge;
    // the rest is raw noise over the whole field range.
    task automatic random_request(input int unsigned span);
        logic              op;
        logic [ELEM_W-1:0] a;
        logic [ELEM_W-1:0] b;
        if ($urandom_range(99) < 12) begin
            op = 1'($urandom_range(1));
            a  = ELEM_W'($urandom_range(2047));
            b  = ELEM_W'($urandom_range(2047));
        end else begin
            op = ($urandom_range(99) < 65) ? OP_UNION : OP_FIND;
            a  = pick_element(span);
            b  = (op == OP_UNION) ? pick_element(span) : ELEM_W'($urandom_range(2047));
        end
        send_request(op, a, b);
    endtask

    // Change the element count once every outstanding result has come back.
    task automatic write_count(input logic [ELEM_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (shadow.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow.set_count(value);
    endtask

    initial begin
        shadow = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests at the count left by reset.
        send_request(OP_FIND, 11'd1, 11'd1);
        send_request(OP_FIND, 11'd1024, 11'd0);
        send_request(OP_FIND, 11'd0, 11'd5);
        send_request(OP_FIND, 11'd1025, 11'd5);
        send_request(OP_FIND, 11'd2047, 11'd2047);
        send_request(OP_FIND, 11'd5, 11'd2047);
        send_request(OP_UNION, 11'd0, 11'd3);
        send_request(OP_UNION, 11'd3, 11'd1025);
        send_request(OP_UNION, 11'd3, 11'd0);
        send_request(OP_UNION, 11'd1, 11'd2);
        send_request(OP_UNION, 11'd3, 11'd1);
        send_request(OP_UNION, 11'd1, 11'd3);
        send_request(OP_UNION, 11'd1024, 11'd1023);
        send_request(OP_UNION, 11'd2, 11'd1024);
        send_request(OP_UNION, 11'd4, 11'd5);
        send_request(OP_UNION, 11'd6, 11'd7);
        send_request(OP_UNION, 11'd4, 11'd6);
        send_request(OP_UNION, 11'd682, 11'd341);
        send_request(OP_UNION, 11'd5, 11'd1024);
        send_request(OP_FIND, 11'd1024, 11'd1024);
        send_request(OP_FIND, 11'd7, 11'd682);
        send_request(OP_FIND, 11'd7, 11'd0);
        send_request(OP_UNION, 11'd1023, 11'd1023);

        // Random phases over a spread of element counts; the stores carry over.
        for (int p = 0; p < PHASES; p++) begin
            write_count(ELEM_W'(phase_count[p]));
            gaps_on  = (p != QUIET);
            window_w = (phase_count[p] < 48) ? phase_count[p] : 48;
            for (int n = 0; n < phase_items[p]; n++) begin
                if (n % 32 == 0)
                    window_lo = $urandom_range(phase_count[p] - window_w + 1, 1);
                random_request(phase_count[p]);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (shadow.pending() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("Checked %0d results: %0d finds, %0d unions (%0d joined two sets),",
                 shadow.results, shadow.finds, shadow.unions, shadow.joins);
        $display("%0d out-of-range requests, element counts from 1 to 1024.", shadow.rejects);
        if (shadow.mismatches == 0 && shadow.pending() == 0) begin
            $display("tb_union_find_by_size_top: clean");
        end else begin
            $display("tb_union_find_by_size_top: errors");
        end
        $finish;
    end

    // Hang guard, several times the slowest legal run.
    initial begin
        #10_000_000;
        $display("tb_union_find_by_size_top: errors");
        $finish;
    end

endmodule
